// ----- design/grwgi_pkg.sv -----
// ----------------------------------------------------------------------------
// grwgi_pkg: shared types and constants of the grain ring writer
// Request and response payloads, slot entry layout, operation codes and ring
// sizing used by the top level, the slot store and the modulo unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package grwgi_pkg;

  localparam int RING_DEPTH       = 16;
  localparam int INVALID_FLAG_BIT = 0;

  localparam int OFF_W   = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int GRAIN_W = 64;

  // Modulo unit consumes one hex digit of the dividend per cycle.
  localparam int MOD_DIGIT_W = 4;
  localparam int MOD_STEPS   = GRAIN_W / MOD_DIGIT_W;
  localparam int STEP_W      = $clog2(MOD_STEPS);

  localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = CNT_W'(RING_DEPTH);
  localparam logic [31:0]      INVALID_MASK     = 32'(1) << INVALID_FLAG_BIT;

  // Operation codes.
  localparam logic [1:0] FUNC_OPEN   = 2'd0;
  localparam logic [1:0] FUNC_COMMIT = 2'd1;
  localparam logic [1:0] FUNC_CANCEL = 2'd2;

  // Status codes.
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_INVALID = 1'b1;

  // Configuration register word indexes.
  localparam logic REG_SLOT_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]         func;
    logic [GRAIN_W-1:0] grain_index;
    logic [15:0]        valid_slices;
    logic [15:0]        total_slices;
    logic [31:0]        grain_flags;
    logic [63:0]        time_now;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [3:0]         slot_offset;
    logic [GRAIN_W-1:0] slot_index;
    logic [15:0]        slot_valid_slices;
    logic [15:0]        slot_total_slices;
    logic [31:0]        slot_flags;
    logic [GRAIN_W-1:0] head_index;
    logic [63:0]        last_write_time;
    logic [31:0]        sync_count;
    logic               wake_readers;
  } rsp_t;

  typedef struct packed {
    logic [GRAIN_W-1:0] index;
    logic [15:0]        valid_slices;
    logic [15:0]        total_slices;
    logic [31:0]        flags;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [OFF_W-1:0] addr;
    entry_t           data;
  } store_wr_t;

  typedef struct packed {
    logic               start;
    logic [GRAIN_W-1:0] dividend;
    logic [CNT_W-1:0]   divisor;
  } mod_req_t;

endpackage

`default_nettype wire

// ----- design/grain_ring_writer_gap_invalidate.sv -----
// ----------------------------------------------------------------------------
// grain_ring_writer_gap_invalidate: writer side of a ring of grain slots
// One request at a time. Open and commit each run one slot-offset modulo on a
// shared digit-serial unit over the 64-bit index, plus sequencing; an open also
// stamps the skipped slots invalid, at most the slot count of them, one slot
// per cycle through the single store write port. Cancel and rejected requests
// skip the modulo and answer from the reply state. The response sits in an
// output register, so a new request is taken while the last one waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grain_ring_writer_gap_invalidate (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire grwgi_pkg::req_t    in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output grwgi_pkg::rsp_t         out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MOD    = 6'b000010,
    S_GAP    = 6'b000100,
    S_OPEN   = 6'b001000,
    S_COMMIT = 6'b010000,
    S_REPLY  = 6'b100000
  } state_t;

  state_t                          state;
  grwgi_pkg::req_t                 req;
  logic                            reply_fail;
  logic [grwgi_pkg::OFF_W-1:0]     off;
  logic [grwgi_pkg::OFF_W-1:0]     gap_off;
  logic [grwgi_pkg::CNT_W-1:0]     gap_left;
  logic [grwgi_pkg::GRAIN_W-1:0]   miss;

  logic [grwgi_pkg::CNT_W-1:0]     slot_count;
  logic [grwgi_pkg::GRAIN_W-1:0]   open_index;
  logic                            open_present;
  logic [grwgi_pkg::GRAIN_W-1:0]   committed_index;
  logic                            committed_present;
  logic [grwgi_pkg::GRAIN_W-1:0]   head;
  logic [63:0]                     write_time;
  logic [31:0]                     sync;

  logic [grwgi_pkg::CNT_W-1:0]     used_count;
  logic                            accept;
  logic                            out_free;
  logic                            load;
  logic                            open_fail;
  logic                            commit_fail;

  grwgi_pkg::mod_req_t             mod_req;
  logic                            mod_done;
  logic [grwgi_pkg::OFF_W-1:0]     mod_rem;
  grwgi_pkg::store_wr_t            st_wr;
  logic [grwgi_pkg::OFF_W-1:0]     st_raddr;
  grwgi_pkg::entry_t               st_rdata;
  grwgi_pkg::rsp_t                 rsp_next;

  logic [grwgi_pkg::GRAIN_W-1:0]   skipped;
  logic [grwgi_pkg::CNT_W-1:0]     gap_n;
  logic [grwgi_pkg::CNT_W-1:0]     gap_start;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == grwgi_pkg::REG_SLOT_COUNT) ? 32'(slot_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= grwgi_pkg::SLOT_COUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == grwgi_pkg::REG_SLOT_COUNT) begin
      slot_count <= pwdata[grwgi_pkg::CNT_W-1:0];
    end
  end

  // A slot count of zero acts as one; anything above the ring depth is clamped.
  always_comb begin
    if (slot_count == '0) begin
      used_count = grwgi_pkg::CNT_W'(1);
    end else if (slot_count > grwgi_pkg::CNT_W'(grwgi_pkg::RING_DEPTH)) begin
      used_count = grwgi_pkg::CNT_W'(grwgi_pkg::RING_DEPTH);
    end else begin
      used_count = slot_count;
    end
  end

  // ---------------- request intake ----------------
  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign open_fail   = committed_present && (in_data.grain_index <= committed_index);
  assign commit_fail = !open_present || (in_data.grain_index != open_index);

  always_comb begin
    mod_req          = '0;
    mod_req.dividend = in_data.grain_index;
    mod_req.divisor  = used_count;
    if (accept) begin
      unique case (in_data.func)
        grwgi_pkg::FUNC_OPEN:   mod_req.start = !open_fail;
        grwgi_pkg::FUNC_COMMIT: mod_req.start = !commit_fail;
        default:                mod_req.start = 1'b0;
      endcase
    end
  end

  grwgi_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .done (mod_done),
    .rem  (mod_rem)
  );

  // Number of skipped slots to invalidate, capped at the slot count.
  assign skipped = req.grain_index - committed_index - grwgi_pkg::GRAIN_W'(1);
  always_comb begin
    if (!committed_present) begin
      gap_n = '0;
    end else if (skipped >= grwgi_pkg::GRAIN_W'(used_count)) begin
      gap_n = used_count;
    end else begin
      gap_n = skipped[grwgi_pkg::CNT_W-1:0];
    end
  end

  // First skipped slot lies gap_left slots behind the opened one, modulo count.
  assign gap_start = grwgi_pkg::CNT_W'(mod_rem)
                   + ((gap_left > grwgi_pkg::CNT_W'(mod_rem)) ? used_count : '0)
                   - gap_left;

  // ---------------- slot store ----------------
  always_comb begin
    st_wr      = '0;
    st_wr.addr = off;
    st_wr.data = st_rdata;
    st_raddr   = off;
    unique case (state)
      S_GAP: begin
        st_raddr                = gap_off;
        st_wr.we                = 1'b1;
        st_wr.addr              = gap_off;
        st_wr.data.index        = miss;
        st_wr.data.valid_slices = '0;
        st_wr.data.flags        = st_rdata.flags | grwgi_pkg::INVALID_MASK;
      end
      S_OPEN: begin
        st_wr.we          = out_free;
        st_wr.data.index  = req.grain_index;
        st_wr.data.flags  = st_rdata.flags & ~grwgi_pkg::INVALID_MASK;
      end
      S_COMMIT: begin
        st_wr.we                = out_free;
        st_wr.data.index        = req.grain_index;
        st_wr.data.valid_slices = req.valid_slices;
        st_wr.data.total_slices = req.total_slices;
        st_wr.data.flags        = req.grain_flags;
      end
      default: st_wr.we = 1'b0;
    endcase
  end

  grwgi_slot_store u_store (
    .clk   (clk),
    .rst   (rst),
    .wr    (st_wr),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // ---------------- response ----------------
  always_comb begin
    rsp_next                 = '0;
    rsp_next.status          = grwgi_pkg::ST_OK;
    rsp_next.head_index      = head;
    rsp_next.last_write_time = write_time;
    rsp_next.sync_count      = sync;
    load                     = 1'b0;
    unique case (state)
      S_OPEN: begin
        load                       = out_free;
        rsp_next.slot_offset       = 4'(off);
        rsp_next.slot_index        = st_wr.data.index;
        rsp_next.slot_valid_slices = st_wr.data.valid_slices;
        rsp_next.slot_total_slices = st_wr.data.total_slices;
        rsp_next.slot_flags        = st_wr.data.flags;
      end
      S_COMMIT: begin
        load                     = out_free;
        rsp_next.head_index      = req.grain_index;
        rsp_next.last_write_time = req.time_now;
        rsp_next.sync_count      = sync + 32'd1;
        rsp_next.wake_readers    = 1'b1;
      end
      S_REPLY: begin
        load            = out_free;
        rsp_next.status = reply_fail;
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= rsp_next;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      open_index        <= '0;
      open_present      <= 1'b0;
      committed_index   <= '0;
      committed_present <= 1'b0;
      head              <= '0;
      write_time        <= '0;
      sync              <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_data.func)
              grwgi_pkg::FUNC_OPEN:   state <= open_fail ? S_REPLY : S_MOD;
              grwgi_pkg::FUNC_COMMIT: state <= commit_fail ? S_REPLY : S_MOD;
              default:                state <= S_REPLY;
            endcase
          end
        end
        S_MOD: begin
          if (mod_done) begin
            if (req.func == grwgi_pkg::FUNC_COMMIT) begin
              state <= S_COMMIT;
            end else if (gap_left != '0) begin
              state <= S_GAP;
            end else begin
              state <= S_OPEN;
            end
          end
        end
        S_GAP: begin
          if (gap_left == grwgi_pkg::CNT_W'(1)) begin
            state <= S_OPEN;
          end
        end
        S_OPEN: begin
          if (out_free) begin
            open_index   <= req.grain_index;
            open_present <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            head       <= req.grain_index;
            write_time <= req.time_now;
            sync       <= sync + 32'd1;
            // A commit with every slice valid closes the grain.
            if (req.valid_slices == req.total_slices) begin
              open_present      <= 1'b0;
              open_index        <= '0;
              committed_index   <= req.grain_index;
              committed_present <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            if (req.func == grwgi_pkg::FUNC_CANCEL) begin
              open_present <= 1'b0;
              open_index   <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req        <= in_data;
      reply_fail <= (in_data.func == grwgi_pkg::FUNC_CANCEL) ? grwgi_pkg::ST_OK
                                                             : grwgi_pkg::ST_INVALID;
    end
    unique case (state)
      S_MOD: begin
        gap_left <= gap_n;
        if (mod_done) begin
          off     <= mod_rem;
          gap_off <= gap_start[grwgi_pkg::OFF_W-1:0];
          miss    <= req.grain_index - grwgi_pkg::GRAIN_W'(gap_left);
        end
      end
      S_GAP: begin
        gap_left <= gap_left - grwgi_pkg::CNT_W'(1);
        miss     <= miss + grwgi_pkg::GRAIN_W'(1);
        if (gap_off == grwgi_pkg::OFF_W'(used_count - grwgi_pkg::CNT_W'(1))) begin
          gap_off <= '0;
        end else begin
          gap_off <= gap_off + grwgi_pkg::OFF_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/grwgi_slot_store.sv -----
// ----------------------------------------------------------------------------
// grwgi_slot_store: ring slot storage
// One entry per ring slot with a valid bit each; an entry never written since
// reset reads as all zero. One combinational read port, one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grwgi_slot_store (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire grwgi_pkg::store_wr_t           wr,
  input  wire logic [grwgi_pkg::OFF_W-1:0]    raddr,
  output grwgi_pkg::entry_t                   rdata
);

  grwgi_pkg::entry_t                      entries [grwgi_pkg::RING_DEPTH];
  logic [grwgi_pkg::RING_DEPTH-1:0]       written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.we) begin
      written[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      entries[wr.addr] <= wr.data;
    end
  end

  assign rdata = written[raddr] ? entries[raddr] : '0;

endmodule

`default_nettype wire

// ----- design/grwgi_mod_unit.sv -----
// ----------------------------------------------------------------------------
// grwgi_mod_unit: iterative modulo of a grain index by the slot count
// Restoring remainder, one hex digit of the dividend per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grwgi_mod_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire grwgi_pkg::mod_req_t         req,
  output logic                             done,
  output logic [grwgi_pkg::OFF_W-1:0]      rem
);

  logic                                busy;
  logic [grwgi_pkg::STEP_W-1:0]        step;
  logic [grwgi_pkg::GRAIN_W-1:0]       shift;
  logic [grwgi_pkg::CNT_W-1:0]         divisor;
  logic [grwgi_pkg::OFF_W-1:0]         rem_next;

  always_comb begin
    logic [grwgi_pkg::MOD_DIGIT_W-1:0] digit;
    logic [grwgi_pkg::OFF_W:0]         trial;
    logic [grwgi_pkg::OFF_W-1:0]       r;
    digit = shift[grwgi_pkg::GRAIN_W-1 -: grwgi_pkg::MOD_DIGIT_W];
    r     = rem;
    for (int i = grwgi_pkg::MOD_DIGIT_W - 1; i >= 0; i--) begin
      trial = {r, digit[i]};
      if (trial >= (grwgi_pkg::OFF_W + 1)'(divisor)) begin
        trial = trial - (grwgi_pkg::OFF_W + 1)'(divisor);
      end
      r = trial[grwgi_pkg::OFF_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + grwgi_pkg::STEP_W'(1);
        if (step == grwgi_pkg::STEP_W'(grwgi_pkg::MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shift   <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      shift <= shift << grwgi_pkg::MOD_DIGIT_W;
      rem   <= rem_next;
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_grain_ring_writer_gap_invalidate.sv -----
// ----------------------------------------------------------------------------
// tb_grain_ring_writer_gap_invalidate: self-checking bench for the ring writer
// Sends open, commit, cancel and unknown requests, mostly well-formed grain
// sequences with random gaps and contents, over several slot-count settings.
// Every response is checked field by field against an in-bench ring model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_grain_ring_writer_gap_invalidate;

  localparam logic [1:0]  FUNC_UNKNOWN    = 2'd3;
  localparam logic [2:0]  SLOT_COUNT_ADDR = {grwgi_pkg::REG_SLOT_COUNT, 2'b00};
  localparam logic [63:0] GRAIN_MAX       = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam logic [31:0] INVALID_BIT     = 32'd1 << grwgi_pkg::INVALID_FLAG_BIT;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 180;
  localparam int SETTLE       = 60;
  localparam int STUCK_LIMIT  = 3000;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  grwgi_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  grwgi_pkg::rsp_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  grain_ring_writer_gap_invalidate i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Model of the ring state.
  logic [63:0] slot_idx_m   [grwgi_pkg::RING_DEPTH];
  logic [15:0] slot_vs_m    [grwgi_pkg::RING_DEPTH];
  logic [15:0] slot_ts_m    [grwgi_pkg::RING_DEPTH];
  logic [31:0] slot_flags_m [grwgi_pkg::RING_DEPTH];
  logic [63:0] open_idx_m = '0;
  logic        open_m = 1'b0;
  logic [63:0] committed_idx_m = '0;
  logic        committed_m = 1'b0;
  logic [63:0] head_m = '0;
  logic [63:0] wtime_m = '0;
  logic [31:0] sync_m = '0;
  logic [4:0]  slot_count_m = 5'd16;

  grwgi_pkg::req_t grain_req_q [$];
  grwgi_pkg::rsp_t ring_rsp_q [$];
  int   req_issued = 0;
  int   req_taken = 0;
  int   phase_items = 0;
  int   errors = 0;
  int   stuck_cycles = 0;
  logic calm;

  // No idling on either side for a stretch in the middle of the run.
  assign calm = (req_taken >= 500) && (req_taken < 700);

  function automatic grwgi_pkg::rsp_t predict_ring_op(grwgi_pkg::req_t r);
    grwgi_pkg::rsp_t o;
    logic [63:0] cnt, n, k, miss, idx;
    logic [3:0] at;
    o = '0;
    o.status = grwgi_pkg::ST_OK;
    idx = r.grain_index;
    if (slot_count_m == 5'd0) cnt = 64'd1;
    else if (slot_count_m > grwgi_pkg::RING_DEPTH) cnt = 64'(grwgi_pkg::RING_DEPTH);
    else cnt = 64'(slot_count_m);
    case (r.func)
      grwgi_pkg::FUNC_OPEN: begin
        if (committed_m && idx <= committed_idx_m) begin
          o.status = grwgi_pkg::ST_INVALID;
        end else begin
          // Skipped grains are stamped invalid, at most one lap of the ring.
          if (committed_m && idx > committed_idx_m + 64'd1) begin
            n = idx - committed_idx_m - 64'd1;
            if (n > cnt) n = cnt;
            for (k = n; k > 0; k--) begin
              miss = idx - k;
              at = 4'(miss % cnt);
              slot_idx_m[at] = miss;
              slot_vs_m[at] = '0;
              slot_flags_m[at] = slot_flags_m[at] | INVALID_BIT;
            end
          end
          at = 4'(idx % cnt);
          slot_idx_m[at] = idx;
          slot_flags_m[at] = slot_flags_m[at] & ~INVALID_BIT;
          o.slot_offset = at;
          o.slot_index = slot_idx_m[at];
          o.slot_valid_slices = slot_vs_m[at];
          o.slot_total_slices = slot_ts_m[at];
          o.slot_flags = slot_flags_m[at];
          open_idx_m = idx;
          open_m = 1'b1;
        end
      end
      grwgi_pkg::FUNC_COMMIT: begin
        if (!open_m || idx != open_idx_m) begin
          o.status = grwgi_pkg::ST_INVALID;
        end else begin
          head_m = open_idx_m;
          at = 4'(open_idx_m % cnt);
          slot_idx_m[at] = idx;
          slot_vs_m[at] = r.valid_slices;
          slot_ts_m[at] = r.total_slices;
          slot_flags_m[at] = r.grain_flags;
          wtime_m = r.time_now;
          if (r.valid_slices == r.total_slices) begin
            open_m = 1'b0;
            open_idx_m = '0;
            committed_idx_m = idx;
            committed_m = 1'b1;
          end
          sync_m = sync_m + 32'd1;
          o.wake_readers = 1'b1;
        end
      end
      grwgi_pkg::FUNC_CANCEL: begin
        open_m = 1'b0;
        open_idx_m = '0;
      end
      default: begin
        o.status = grwgi_pkg::ST_INVALID;
      end
    endcase
    o.head_index = head_m;
    o.last_write_time = wtime_m;
    o.sync_count = sync_m;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  function automatic logic [63:0] rand_index();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (v > GRAIN_MAX) v = GRAIN_MAX;
    return v;
  endfunction

  function automatic grwgi_pkg::req_t rand_req(logic [1:0] f, logic [63:0] idx);
    grwgi_pkg::req_t r;
    r.func = f;
    r.grain_index = idx;
    r.valid_slices = 16'($urandom);
    r.total_slices = 16'($urandom);
    r.grain_flags = $urandom;
    r.time_now = {$urandom, $urandom};
    return r;
  endfunction

  task automatic push_req(grwgi_pkg::req_t r);
    grain_req_q.push_back(r);
    req_issued++;
    phase_items++;
  endtask

  task automatic push_commit(logic [63:0] idx, logic full);
    grwgi_pkg::req_t r;
    r = rand_req(grwgi_pkg::FUNC_COMMIT, idx);
    if (full) r.valid_slices = r.total_slices;
    else r.valid_slices = r.total_slices + 16'(1 + $urandom_range(65534));
    push_req(r);
  endtask

  // Waits until every request has been answered and the block has settled.
  task automatic settle();
    while (!(req_taken == req_issued && ring_rsp_q.size() == 0)) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_slot_count(logic [4:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SLOT_COUNT_ADDR;
    pwdata <= {$urandom} & ~32'h1F | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    grwgi_pkg::req_t r;
    logic [63:0] cursor, tmp;
    int p, sel, gap;
    int unsigned slot_count_plan [NUM_PHASES];
    slot_count_plan = '{1, 0, 16, 31, 3, 17, 9, 12};
    for (int i = 0; i < grwgi_pkg::RING_DEPTH; i++) begin
      slot_idx_m[i] = '0;
      slot_vs_m[i] = '0;
      slot_ts_m[i] = '0;
      slot_flags_m[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset slot count.
    push_req(rand_req(grwgi_pkg::FUNC_CANCEL, 64'd0));
    r = '1;
    r.func = FUNC_UNKNOWN;
    r.grain_index = GRAIN_MAX;
    push_req(r);
    push_commit(64'd0, 1'b1);
    push_req(rand_req(grwgi_pkg::FUNC_OPEN, GRAIN_MAX));
    push_commit(GRAIN_MAX - 64'd1, 1'b1);
    push_req(rand_req(grwgi_pkg::FUNC_CANCEL, GRAIN_MAX));
    push_req(rand_req(grwgi_pkg::FUNC_OPEN, 64'd0));
    r = rand_req(grwgi_pkg::FUNC_COMMIT, 64'd0);
    r.valid_slices = 16'd0;
    r.total_slices = 16'hFFFF;
    r.grain_flags = '1;
    r.time_now = '1;
    push_req(r);
    r.valid_slices = 16'hFFFF;
    r.grain_flags = '0;
    r.time_now = '0;
    push_req(r);
    push_req(rand_req(grwgi_pkg::FUNC_OPEN, 64'd0));
    push_req(rand_req(grwgi_pkg::FUNC_OPEN, 64'd1));
    r = rand_req(grwgi_pkg::FUNC_COMMIT, 64'd1);
    r.valid_slices = 16'd0;
    r.total_slices = 16'd0;
    push_req(r);
    push_req(rand_req(grwgi_pkg::FUNC_OPEN, 64'd6));
    push_req(rand_req(grwgi_pkg::FUNC_OPEN, 64'd40));
    push_commit(64'd6, 1'b1);
    push_commit(64'd40, 1'b1);
    push_req(rand_req(grwgi_pkg::FUNC_OPEN, 64'd41));
    push_req(rand_req(grwgi_pkg::FUNC_CANCEL, 64'd41));
    push_commit(64'd41, 1'b1);
    push_req(rand_req(grwgi_pkg::FUNC_OPEN, 64'd42));
    push_commit(64'd42, 1'b1);
    cursor = 64'd43;
    push_req(rand_req(grwgi_pkg::FUNC_OPEN, cursor));

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p == NUM_PHASES - 1) write_slot_count(5'($urandom_range(31)));
      else write_slot_count(5'(slot_count_plan[p]));
      phase_items = 0;
      // The grain left open before the write now commits under the new count.
      push_commit(cursor, 1'b1);
      if (p == 3) begin
        tmp = {$urandom, $urandom};
        tmp[63] = 1'b0;
        if (tmp > cursor) cursor = tmp;
      end
      if (p == 6) cursor = 64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(255));
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(99) < 82) begin
          sel = $urandom_range(99);
          if (sel < 55) gap = 0;
          else if (sel < 80) gap = $urandom_range(1, 3);
          else if (sel < 93) gap = $urandom_range(4, 20);
          else gap = $urandom_range(17, 40);
          cursor = cursor + 64'd1 + 64'(gap);
          push_req(rand_req(grwgi_pkg::FUNC_OPEN, cursor));
          if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) push_commit(cursor, 1'b0);
          end
          sel = $urandom_range(99);
          if (sel < 80) push_commit(cursor, 1'b1);
          else if (sel < 90) push_req(rand_req(grwgi_pkg::FUNC_CANCEL, cursor));
        end else begin
          case ($urandom_range(5))
            0: push_req(rand_req(FUNC_UNKNOWN, rand_index()));
            1: push_req(rand_req(grwgi_pkg::FUNC_CANCEL, rand_index()));
            2: push_req(rand_req(grwgi_pkg::FUNC_OPEN, cursor - 64'($urandom_range(3))));
            3: push_req(rand_req(grwgi_pkg::FUNC_OPEN, rand_index()));
            4: push_commit(rand_index(), 1'($urandom_range(1)));
            default: push_commit(cursor + 64'($urandom_range(1)), 1'b1);
          endcase
        end
      end
      cursor = cursor + 64'd1;
      push_req(rand_req(grwgi_pkg::FUNC_OPEN, cursor));
    end

    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Request driver: the payload holds until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (grain_req_q.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
        in_valid <= 1'b1;
        in_data <= grain_req_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 36);
    end
  end

  // Response checking, then prediction for a request taken at this edge.
  always @(posedge clk) begin
    grwgi_pkg::rsp_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (ring_rsp_q.size() == 0) begin
          report_mismatch("response with no request outstanding", 64'(out_data.status), 0);
        end else begin
          want = ring_rsp_q.pop_front();
          check_field("status", 64'(out_data.status), 64'(want.status));
          check_field("slot_offset", 64'(out_data.slot_offset), 64'(want.slot_offset));
          check_field("slot_index", out_data.slot_index, want.slot_index);
          check_field("slot_valid_slices", 64'(out_data.slot_valid_slices),
                      64'(want.slot_valid_slices));
          check_field("slot_total_slices", 64'(out_data.slot_total_slices),
                      64'(want.slot_total_slices));
          check_field("slot_flags", 64'(out_data.slot_flags), 64'(want.slot_flags));
          check_field("head_index", out_data.head_index, want.head_index);
          check_field("last_write_time", out_data.last_write_time, want.last_write_time);
          check_field("sync_count", 64'(out_data.sync_count), 64'(want.sync_count));
          check_field("wake_readers", 64'(out_data.wake_readers), 64'(want.wake_readers));
        end
      end
      if (in_valid && !in_stall) begin
        ring_rsp_q.push_back(predict_ring_op(in_data));
        req_taken++;
      end
      if (psel && penable && pwrite && pready && paddr == SLOT_COUNT_ADDR) begin
        slot_count_m = pwdata[4:0];
      end
    end
  end

  // Watchdog on cycles in which no request or response moves.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
